/* hw/rtl/ctc_pkg.sv */
package ctc_pkg;

  localparam int TICKS_PER_SECOND_DEF   = 10;
  localparam int SECONDS_PER_MINUTE_DEF = 60;

  localparam int TEMP_W      = 12;
  localparam int CNT_W       = 16;
  localparam int STEP_W      = 3;
  localparam int OFF_DELAY_W = 14;
  localparam int PSAVE_W     = 2;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // Temperatures are in 0.1 C units.
  localparam logic signed [TEMP_W-1:0] TEMP_START_NORMAL = 12'sd80;
  localparam logic signed [TEMP_W-1:0] TEMP_START_SAVE   = 12'sd100;
  localparam logic signed [TEMP_W-1:0] TEMP_STOP         = 12'sd60;
  localparam logic signed [TEMP_W-1:0] TEMP_FREEZE       = 12'sd10;

  // Off-delay reload values in ticks.
  localparam logic [OFF_DELAY_W-1:0] OFF_DELAY_LOW  = 14'd9000;
  localparam logic [OFF_DELAY_W-1:0] OFF_DELAY_HIGH = 14'd12000;

  localparam logic [STEP_W-1:0] STEP_FAULT = 3'd0;
  localparam logic [STEP_W-1:0] STEP_1     = 3'd1;
  localparam logic [STEP_W-1:0] STEP_2     = 3'd2;
  localparam logic [STEP_W-1:0] STEP_3     = 3'd3;
  localparam logic [STEP_W-1:0] STEP_4     = 3'd4;

  localparam logic [PSAVE_W-1:0] PSAVE_NORMAL = 2'd0;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_START_DELAY,
    CFG_MAX_RUN,
    CFG_COLD_OFF_WATCH,
    CFG_AIR_STEP1,
    CFG_AIR_STEP2,
    CFG_AIR_STEP3
  } cfg_reg_t;

  typedef struct packed {
    logic [CNT_W-1:0]         start_delay_seconds;
    logic [CNT_W-1:0]         max_run_seconds;
    logic [CNT_W-1:0]         cold_off_watch_minutes;
    logic signed [TEMP_W-1:0] air_step1_limit;
    logic signed [TEMP_W-1:0] air_step2_limit;
    logic signed [TEMP_W-1:0] air_step3_limit;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    start_delay_seconds:    16'd300,
    max_run_seconds:        16'd7200,
    cold_off_watch_minutes: 16'd1440,
    air_step1_limit:        12'sd100,
    air_step2_limit:        12'sd200,
    air_step3_limit:        12'sd300
  };

  typedef struct packed {
    logic signed [TEMP_W-1:0] cold_water_temp;
    logic signed [TEMP_W-1:0] air_temp;
    logic                     air_sensor_fault;
    logic                     cold_function_on;
    logic                     cold_fault;
    logic                     low_level_seen;
    logic [PSAVE_W-1:0]       power_save_mode;
    logic                     manual_test_mode;
    logic                     manual_test_run;
  } item_t;

  typedef struct packed {
    logic               compressor_on;
    logic [STEP_W-1:0]  cool_step;
    logic               start_delay_done;
    logic [CNT_W-1:0]   start_delay_elapsed;
    logic               max_run_reached;
    logic               cold_off_long;
  } result_t;

endpackage

/* hw/rtl/ctc_air_step.sv */
module ctc_air_step (
  input  logic signed [ctc_pkg::TEMP_W-1:0] air_temp,
  input  logic                              air_sensor_fault,
  input  ctc_pkg::cfg_t                     cfg,
  output logic [ctc_pkg::STEP_W-1:0]        step
);
  import ctc_pkg::*;

  always_comb begin
    if (air_sensor_fault) begin
      step = STEP_FAULT;
    end else if (air_temp < cfg.air_step1_limit) begin
      step = STEP_1;
    end else if (air_temp < cfg.air_step2_limit) begin
      step = STEP_2;
    end else if (air_temp < cfg.air_step3_limit) begin
      step = STEP_3;
    end else begin
      step = STEP_4;
    end
  end

endmodule

/* hw/rtl/ctc_core.sv */
module ctc_core #(
  parameter int TICKS_PER_SECOND   = ctc_pkg::TICKS_PER_SECOND_DEF,
  parameter int SECONDS_PER_MINUTE = ctc_pkg::SECONDS_PER_MINUTE_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step_en,
  input  ctc_pkg::cfg_t    cfg,
  input  ctc_pkg::item_t   item,
  output ctc_pkg::result_t res_next
);
  import ctc_pkg::*;

  localparam int TP_W = $clog2(TICKS_PER_SECOND + 1);
  localparam int SP_W = $clog2(SECONDS_PER_MINUTE + 1);
  localparam logic [TP_W-1:0] TP_LAST = TP_W'(TICKS_PER_SECOND - 1);
  localparam logic [SP_W-1:0] SP_LAST = SP_W'(SECONDS_PER_MINUTE - 1);

  logic                   comp_running;
  logic [TP_W-1:0]        tenth_prescale;
  logic [SP_W-1:0]        second_prescale;
  logic [CNT_W-1:0]       start_delay_count;
  logic [CNT_W-1:0]       run_count;
  logic [CNT_W-1:0]       off_minutes;
  logic [OFF_DELAY_W-1:0] off_delay_count;
  logic [STEP_W-1:0]      step_held;
  logic                   manual_run_last;

  logic                   comp_running_next;
  logic [TP_W-1:0]        tenth_prescale_next;
  logic [SP_W-1:0]        second_prescale_next;
  logic [CNT_W-1:0]       start_delay_count_next;
  logic [CNT_W-1:0]       run_count_next;
  logic [CNT_W-1:0]       off_minutes_next;
  logic [OFF_DELAY_W-1:0] off_delay_count_next;
  logic [STEP_W-1:0]      step_held_next;

  logic                   tenth_fire;
  logic                   second_fire;
  logic                   delay_done;
  logic                   max_done;
  logic [STEP_W-1:0]      air_step;
  logic signed [TEMP_W-1:0] start_temp;

  ctc_air_step u_air_step (
    .air_temp         (item.air_temp),
    .air_sensor_fault (item.air_sensor_fault),
    .cfg              (cfg),
    .step             (air_step)
  );

  assign tenth_fire  = (tenth_prescale == TP_LAST);
  assign second_fire = (second_prescale == SP_LAST);
  assign start_temp  = (item.power_save_mode == PSAVE_NORMAL) ? TEMP_START_NORMAL
                                                              : TEMP_START_SAVE;

  always_comb begin
    comp_running_next      = comp_running;
    start_delay_count_next = start_delay_count;
    run_count_next         = run_count;
    off_minutes_next       = off_minutes;
    off_delay_count_next   = off_delay_count;
    step_held_next         = step_held;
    second_prescale_next   = second_prescale;
    tenth_prescale_next    = tenth_fire ? '0 : tenth_prescale + 1'b1;

    if (item.manual_test_mode && item.manual_test_run && !manual_run_last) begin
      start_delay_count_next = cfg.start_delay_seconds;
    end

    // Timers run on the compressor state from before this item.
    if (tenth_fire) begin
      if (!comp_running && (start_delay_count_next < cfg.start_delay_seconds)) begin
        start_delay_count_next = start_delay_count_next + 1'b1;
      end
      if (comp_running) begin
        if (run_count < cfg.max_run_seconds) begin
          run_count_next = (item.cold_water_temp < TEMP_FREEZE) ? cfg.max_run_seconds
                                                                : run_count + 1'b1;
        end
      end else begin
        run_count_next = '0;
      end
      if (second_fire) begin
        second_prescale_next = '0;
        if (!item.cold_function_on) begin
          if (off_minutes < cfg.cold_off_watch_minutes) begin
            off_minutes_next = off_minutes + 1'b1;
          end
        end else begin
          off_minutes_next = '0;
        end
      end else begin
        second_prescale_next = second_prescale + 1'b1;
      end
    end

    delay_done = (start_delay_count_next >= cfg.start_delay_seconds);
    max_done   = (run_count_next >= cfg.max_run_seconds);

    if (item.manual_test_mode) begin
      if (item.manual_test_run) begin
        if (delay_done) begin
          comp_running_next = 1'b1;
        end
      end else if (comp_running) begin
        comp_running_next      = 1'b0;
        start_delay_count_next = '0;
      end
    end else if (!item.cold_function_on) begin
      if (comp_running) begin
        comp_running_next      = 1'b0;
        start_delay_count_next = '0;
        off_delay_count_next   = '0;
      end
    end else if (!delay_done) begin
      off_delay_count_next = '0;
      comp_running_next    = 1'b0;
    end else if (max_done || !item.low_level_seen) begin
      if (comp_running) begin
        comp_running_next      = 1'b0;
        start_delay_count_next = '0;
        off_delay_count_next   = '0;
      end
    end else begin
      step_held_next = air_step;
      if (item.cold_fault) begin
        if (comp_running) begin
          comp_running_next      = 1'b0;
          start_delay_count_next = '0;
          off_delay_count_next   = '0;
        end
      end else begin
        if (item.cold_water_temp >= TEMP_STOP) begin
          if (air_step == STEP_FAULT) begin
            off_delay_count_next = '0;
          end else if (air_step <= STEP_2) begin
            off_delay_count_next = OFF_DELAY_LOW;
          end else begin
            off_delay_count_next = OFF_DELAY_HIGH;
          end
        end
        if (item.cold_water_temp > start_temp) begin
          comp_running_next = 1'b1;
        end else if ((item.cold_water_temp < TEMP_STOP) && comp_running) begin
          if (off_delay_count_next == '0) begin
            start_delay_count_next = '0;
            comp_running_next      = 1'b0;
          end else begin
            off_delay_count_next = off_delay_count_next - 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    res_next.compressor_on       = comp_running_next;
    res_next.cool_step           = step_held_next;
    res_next.start_delay_done    = (start_delay_count_next >= cfg.start_delay_seconds);
    res_next.start_delay_elapsed = start_delay_count_next;
    res_next.max_run_reached     = (run_count_next >= cfg.max_run_seconds);
    res_next.cold_off_long       = (off_minutes_next >= cfg.cold_off_watch_minutes);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      comp_running      <= 1'b0;
      tenth_prescale    <= '0;
      second_prescale   <= '0;
      start_delay_count <= '0;
      run_count         <= '0;
      off_minutes       <= '0;
      off_delay_count   <= '0;
      step_held         <= STEP_FAULT;
      manual_run_last   <= 1'b0;
    end else if (step_en) begin
      comp_running      <= comp_running_next;
      tenth_prescale    <= tenth_prescale_next;
      second_prescale   <= second_prescale_next;
      start_delay_count <= start_delay_count_next;
      run_count         <= run_count_next;
      off_minutes       <= off_minutes_next;
      off_delay_count   <= off_delay_count_next;
      step_held         <= step_held_next;
      manual_run_last   <= item.manual_test_run;
    end
  end

endmodule

/* hw/rtl/compressor_thermostat_control_unit.sv */
// Compressor thermostat controller. Each accepted item is one control tick; it
// yields exactly one result item, registered on the outputs when the held item
// advances out of the input register. One item can be accepted every cycle
// while out_stall is low: the item sits in an input register, the whole
// tick update (prescalers, start delay, run limit, off-delay and the on/off
// decision) is one pass of logic into the state and result registers, and the
// result register frees itself whenever out_stall is low. Configuration
// registers hold their reset values until written and take effect on the
// next item processed.
module compressor_thermostat_control_unit #(
  parameter int TICKS_PER_SECOND   = ctc_pkg::TICKS_PER_SECOND_DEF,
  parameter int SECONDS_PER_MINUTE = ctc_pkg::SECONDS_PER_MINUTE_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,

  input  logic                                  cfg_write,
  input  logic [ctc_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [ctc_pkg::CFG_DATA_W-1:0]        cfg_data,

  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [ctc_pkg::TEMP_W-1:0]     cold_water_temp,
  input  logic signed [ctc_pkg::TEMP_W-1:0]     air_temp,
  input  logic                                  air_sensor_fault,
  input  logic                                  cold_function_on,
  input  logic                                  cold_fault,
  input  logic                                  low_level_seen,
  input  logic [ctc_pkg::PSAVE_W-1:0]           power_save_mode,
  input  logic                                  manual_test_mode,
  input  logic                                  manual_test_run,

  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  compressor_on,
  output logic [ctc_pkg::STEP_W-1:0]            cool_step,
  output logic                                  start_delay_done,
  output logic [ctc_pkg::CNT_W-1:0]             start_delay_elapsed,
  output logic                                  max_run_reached,
  output logic                                  cold_off_long
);
  import ctc_pkg::*;

  cfg_t    cfg;
  item_t   in_item;
  logic    in_full;
  result_t res_next;
  result_t res;
  logic    advance;
  logic    accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_START_DELAY:    cfg.start_delay_seconds    <= cfg_data;
        CFG_MAX_RUN:        cfg.max_run_seconds        <= cfg_data;
        CFG_COLD_OFF_WATCH: cfg.cold_off_watch_minutes <= cfg_data;
        CFG_AIR_STEP1:      cfg.air_step1_limit        <= $signed(cfg_data[TEMP_W-1:0]);
        CFG_AIR_STEP2:      cfg.air_step2_limit        <= $signed(cfg_data[TEMP_W-1:0]);
        CFG_AIR_STEP3:      cfg.air_step3_limit        <= $signed(cfg_data[TEMP_W-1:0]);
        default: begin
        end
      endcase
    end
  end

  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_item.cold_water_temp  <= cold_water_temp;
      in_item.air_temp         <= air_temp;
      in_item.air_sensor_fault <= air_sensor_fault;
      in_item.cold_function_on <= cold_function_on;
      in_item.cold_fault       <= cold_fault;
      in_item.low_level_seen   <= low_level_seen;
      in_item.power_save_mode  <= power_save_mode;
      in_item.manual_test_mode <= manual_test_mode;
      in_item.manual_test_run  <= manual_test_run;
    end
  end

  ctc_core #(
    .TICKS_PER_SECOND   (TICKS_PER_SECOND),
    .SECONDS_PER_MINUTE (SECONDS_PER_MINUTE)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .step_en  (advance),
    .cfg      (cfg),
    .item     (in_item),
    .res_next (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign compressor_on       = res.compressor_on;
  assign cool_step           = res.cool_step;
  assign start_delay_done    = res.start_delay_done;
  assign start_delay_elapsed = res.start_delay_elapsed;
  assign max_run_reached     = res.max_run_reached;
  assign cold_off_long       = res.cold_off_long;

endmodule

/* hw/rtl/ctc_checker.sv */
module ctc_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic                              compressor_on,
  input logic [ctc_pkg::STEP_W-1:0]        cool_step,
  input logic                              start_delay_done,
  input logic [ctc_pkg::CNT_W-1:0]         start_delay_elapsed,
  input logic                              max_run_reached,
  input logic                              cold_off_long
);
  import ctc_pkg::*;

  // A stalled result item stays on the port unchanged.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(compressor_on) && $stable(cool_step)
      && $stable(start_delay_done) && $stable(start_delay_elapsed)
      && $stable(max_run_reached) && $stable(cold_off_long))
    else $error("stalled result item changed");

  // Reset empties both the input and the result register.
  assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

  // With the result register empty, the held item always moves on.
  assert property (@(posedge clk) disable iff (rst) !out_valid |-> !in_stall)
    else $error("input stalled while result register is empty");

  // The air step never leaves its band codes.
  assert property (@(posedge clk) disable iff (rst) out_valid |-> cool_step <= STEP_4)
    else $error("cool_step out of range");

endmodule

bind compressor_thermostat_control_unit ctc_checker u_ctc_checker (.*);

/* dv/compressor_thermostat_control_unit_tb.sv */
`timescale 1ns / 1ps

module compressor_thermostat_control_unit_tb;
  import ctc_pkg::*;

  class compressor_scoreboard;
    logic [CNT_W-1:0]         delay_limit;
    logic [CNT_W-1:0]         run_limit;
    logic [CNT_W-1:0]         watch_limit;
    logic signed [TEMP_W-1:0] lim1;
    logic signed [TEMP_W-1:0] lim2;
    logic signed [TEMP_W-1:0] lim3;

    logic                   running;
    logic                   manual_last;
    logic [3:0]             tenth_cnt;
    logic [5:0]             second_cnt;
    logic [CNT_W-1:0]       delay_cnt;
    logic [CNT_W-1:0]       run_cnt;
    logic [CNT_W-1:0]       off_min;
    logic [OFF_DELAY_W-1:0] off_delay;
    logic [STEP_W-1:0]      step;

    result_t pending_status[$];
    int      mismatches;
    int      checked;

    function new();
      delay_limit = CFG_RESET.start_delay_seconds;
      run_limit   = CFG_RESET.max_run_seconds;
      watch_limit = CFG_RESET.cold_off_watch_minutes;
      lim1        = CFG_RESET.air_step1_limit;
      lim2        = CFG_RESET.air_step2_limit;
      lim3        = CFG_RESET.air_step3_limit;
      running     = 1'b0;
      manual_last = 1'b0;
      tenth_cnt   = '0;
      second_cnt  = '0;
      delay_cnt   = '0;
      run_cnt     = '0;
      off_min     = '0;
      off_delay   = '0;
      step        = STEP_FAULT;
      mismatches  = 0;
      checked     = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_START_DELAY:    delay_limit = val;
        CFG_MAX_RUN:        run_limit = val;
        CFG_COLD_OFF_WATCH: watch_limit = val;
        CFG_AIR_STEP1:      lim1 = val[TEMP_W-1:0];
        CFG_AIR_STEP2:      lim2 = val[TEMP_W-1:0];
        CFG_AIR_STEP3:      lim3 = val[TEMP_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [STEP_W-1:0] air_band(logic signed [TEMP_W-1:0] air, logic fault);
      if (fault) return STEP_FAULT;
      if (air < lim1) return STEP_1;
      if (air < lim2) return STEP_2;
      if (air < lim3) return STEP_3;
      return STEP_4;
    endfunction

    function void stop_run();
      if (running) begin
        delay_cnt = '0;
        off_delay = '0;
        running = 1'b0;
      end
    endfunction

    // The timers see the compressor state from before this tick.
    function void advance_timers(logic signed [TEMP_W-1:0] water, logic cold_on);
      if (tenth_cnt < TICKS_PER_SECOND_DEF - 1) begin
        tenth_cnt++;
        return;
      end
      tenth_cnt = '0;
      if (!running && delay_cnt < delay_limit) delay_cnt++;
      if (running) begin
        if (run_cnt < run_limit) begin
          run_cnt++;
          if (water < TEMP_FREEZE) run_cnt = run_limit;
        end
      end else begin
        run_cnt = '0;
      end
      if (second_cnt < SECONDS_PER_MINUTE_DEF - 1) begin
        second_cnt++;
      end else begin
        second_cnt = '0;
        if (!cold_on) begin
          if (off_min < watch_limit) off_min++;
        end else begin
          off_min = '0;
        end
      end
    endfunction

    function void apply_tick(item_t it);
      logic signed [TEMP_W-1:0] water;
      logic signed [TEMP_W-1:0] air;
      logic signed [TEMP_W-1:0] start_t;
      logic                     delay_done;
      logic                     max_done;
      result_t                  r;
      water = it.cold_water_temp;
      air = it.air_temp;
      if (it.manual_test_mode && it.manual_test_run && !manual_last) delay_cnt = delay_limit;
      manual_last = it.manual_test_run;
      advance_timers(water, it.cold_function_on);
      delay_done = delay_cnt >= delay_limit;
      max_done = run_cnt >= run_limit;
      if (it.manual_test_mode) begin
        if (it.manual_test_run) begin
          if (delay_done) running = 1'b1;
        end else if (running) begin
          running = 1'b0;
          delay_cnt = '0;
        end
      end else if (!it.cold_function_on) begin
        stop_run();
      end else if (!delay_done) begin
        off_delay = '0;
        running = 1'b0;
      end else if (max_done || !it.low_level_seen) begin
        stop_run();
      end else begin
        step = air_band(air, it.air_sensor_fault);
        if (it.cold_fault) begin
          stop_run();
        end else begin
          start_t = (it.power_save_mode == PSAVE_NORMAL) ? TEMP_START_NORMAL : TEMP_START_SAVE;
          if (water >= TEMP_STOP) begin
            off_delay = (step == STEP_FAULT) ? '0 :
                        (step <= STEP_2) ? OFF_DELAY_LOW : OFF_DELAY_HIGH;
          end
          if (water > start_t) begin
            running = 1'b1;
          end else if (water < TEMP_STOP && running) begin
            if (off_delay == '0) begin
              delay_cnt = '0;
              running = 1'b0;
            end else begin
              off_delay--;
            end
          end
        end
      end
      r.compressor_on       = running;
      r.cool_step           = step;
      r.start_delay_done    = delay_cnt >= delay_limit;
      r.start_delay_elapsed = delay_cnt;
      r.max_run_reached     = run_cnt >= run_limit;
      r.cold_off_long       = off_min >= watch_limit;
      pending_status.push_back(r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      if (mismatches <= 40)
        $display("[%0t] result %0d: %s got %0d, expected %0d", $time, checked, what, got, want);
    endtask

    task check_result(result_t got);
      result_t want;
      checked++;
      if (pending_status.size() == 0) begin
        report("unexpected result item", 0, 0);
        return;
      end
      want = pending_status.pop_front();
      if (got.compressor_on !== want.compressor_on)
        report("compressor_on", got.compressor_on, want.compressor_on);
      if (got.cool_step !== want.cool_step)
        report("cool_step", got.cool_step, want.cool_step);
      if (got.start_delay_done !== want.start_delay_done)
        report("start_delay_done", got.start_delay_done, want.start_delay_done);
      if (got.start_delay_elapsed !== want.start_delay_elapsed)
        report("start_delay_elapsed", got.start_delay_elapsed, want.start_delay_elapsed);
      if (got.max_run_reached !== want.max_run_reached)
        report("max_run_reached", got.max_run_reached, want.max_run_reached);
      if (got.cold_off_long !== want.cold_off_long)
        report("cold_off_long", got.cold_off_long, want.cold_off_long);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                     cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;

  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [TEMP_W-1:0] cold_water_temp = '0;
  logic signed [TEMP_W-1:0] air_temp = '0;
  logic                     air_sensor_fault = 1'b0;
  logic                     cold_function_on = 1'b0;
  logic                     cold_fault = 1'b0;
  logic                     low_level_seen = 1'b0;
  logic [PSAVE_W-1:0]       power_save_mode = '0;
  logic                     manual_test_mode = 1'b0;
  logic                     manual_test_run = 1'b0;

  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     compressor_on;
  logic [STEP_W-1:0]        cool_step;
  logic                     start_delay_done;
  logic [CNT_W-1:0]         start_delay_elapsed;
  logic                     max_run_reached;
  logic                     cold_off_long;

  compressor_scoreboard sb = new();

  bit quiet = 1'b0;
  bit cold_on_hold = 1'b1;
  bit manual_hold = 1'b0;
  bit run_hold = 1'b0;
  int stall_left = 0;

  compressor_thermostat_control_unit dut (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_write           (cfg_write),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .cold_water_temp     (cold_water_temp),
    .air_temp            (air_temp),
    .air_sensor_fault    (air_sensor_fault),
    .cold_function_on    (cold_function_on),
    .cold_fault          (cold_fault),
    .low_level_seen      (low_level_seen),
    .power_save_mode     (power_save_mode),
    .manual_test_mode    (manual_test_mode),
    .manual_test_run     (manual_test_run),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .compressor_on       (compressor_on),
    .cool_step           (cool_step),
    .start_delay_done    (start_delay_done),
    .start_delay_elapsed (start_delay_elapsed),
    .max_run_reached     (max_run_reached),
    .cold_off_long       (cold_off_long)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      sb.apply_tick(item_t'{cold_water_temp, air_temp, air_sensor_fault, cold_function_on,
                            cold_fault, low_level_seen, power_save_mode, manual_test_mode,
                            manual_test_run});
    end
    if (!rst && out_valid && !out_stall) begin
      sb.check_result(result_t'{compressor_on, cool_step, start_delay_done,
                                start_delay_elapsed, max_run_reached, cold_off_long});
    end
  end

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      if (stall_left == 0) out_stall <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 14);
      out_stall <= 1'b1;
    end
  end

  function automatic item_t make_tick(int water, int air, bit fault, bit cold_on, bit cfault,
                                      bit low, int psave, bit mmode, bit mrun);
    item_t it;
    it.cold_water_temp  = water[TEMP_W-1:0];
    it.air_temp         = air[TEMP_W-1:0];
    it.air_sensor_fault = fault;
    it.cold_function_on = cold_on;
    it.cold_fault       = cfault;
    it.low_level_seen   = low;
    it.power_save_mode  = psave[PSAVE_W-1:0];
    it.manual_test_mode = mmode;
    it.manual_test_run  = mrun;
    return it;
  endfunction

  // Mostly well-formed control ticks: the cold function and manual mode hold for long
  // stretches, and water sits near the switching thresholds most of the time.
  function automatic item_t random_tick();
    int w;
    int a;
    if ($urandom_range(0, 149) == 0) cold_on_hold = !cold_on_hold;
    if ($urandom_range(0, manual_hold ? 24 : 79) == 0) manual_hold = !manual_hold;
    if ($urandom_range(0, 5) == 0) run_hold = !run_hold;
    case ($urandom_range(0, 5))
      0: w = int'($urandom_range(0, 2000)) - 500;
      1, 2: w = $urandom_range(55, 105);
      3: w = $urandom_range(0, 70);
      default: begin
        case ($urandom_range(0, 3))
          0: w = TEMP_FREEZE;
          1: w = TEMP_STOP;
          2: w = TEMP_START_NORMAL;
          default: w = TEMP_START_SAVE;
        endcase
        w += int'($urandom_range(0, 2)) - 1;
      end
    endcase
    if ($urandom_range(0, 1) == 0) begin
      a = int'($urandom_range(0, 2000)) - 500;
    end else begin
      case ($urandom_range(0, 2))
        0: a = sb.lim1;
        1: a = sb.lim2;
        default: a = sb.lim3;
      endcase
      a += int'($urandom_range(0, 2)) - 1;
      if (a < -500) a = -500;
      if (a > 1500) a = 1500;
    end
    return make_tick(w, a, $urandom_range(0, 5) == 0,
                     cold_on_hold ^ ($urandom_range(0, 49) == 0),
                     $urandom_range(0, 24) == 0, $urandom_range(0, 24) != 0,
                     $urandom_range(0, 3), manual_hold, run_hold);
  endfunction

  task automatic send_tick(input item_t it);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    cold_water_temp  <= it.cold_water_temp;
    air_temp         <= it.air_temp;
    air_sensor_fault <= it.air_sensor_fault;
    cold_function_on <= it.cold_function_on;
    cold_fault       <= it.cold_fault;
    low_level_seen   <= it.low_level_seen;
    power_save_mode  <= it.power_save_mode;
    manual_test_mode <= it.manual_test_mode;
    manual_test_run  <= it.manual_test_run;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic run_phase(int count);
    repeat (count) send_tick(random_tick());
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_setting(int sd, int mr, int wm, int a1, int a2, int a3);
    logic [CFG_DATA_W-1:0] vals [6];
    vals = '{CFG_DATA_W'(sd), CFG_DATA_W'(mr), CFG_DATA_W'(wm),
             CFG_DATA_W'(a1), CFG_DATA_W'(a2), CFG_DATA_W'(a3)};
    drain();
    for (int i = CFG_START_DELAY; i <= CFG_AIR_STEP3; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= cfg_reg_t'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      sb.set_reg(cfg_reg_t'(i), vals[i]);
    end
    cfg_write <= 1'b0;
  endtask

  initial begin
    int a1;
    int a2;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    run_phase(100);

    apply_setting(0, 65535, 0, 100, 200, 300);
    send_tick(make_tick(1500, -500, 0, 1, 0, 1, 0, 0, 0));
    send_tick(make_tick(81, 150, 0, 1, 0, 1, 0, 0, 0));
    send_tick(make_tick(59, 250, 0, 1, 0, 1, 0, 0, 0));
    // With the air sensor faulted the off-delay reloads to zero, so the next cold tick stops.
    send_tick(make_tick(60, 1500, 1, 1, 0, 1, 0, 0, 0));
    send_tick(make_tick(59, 0, 1, 1, 0, 1, 0, 0, 0));
    send_tick(make_tick(100, 0, 0, 1, 0, 1, 1, 0, 0));
    send_tick(make_tick(101, 350, 0, 1, 0, 1, 2, 0, 0));
    // Near-freezing water while running forces the run limit on the next second.
    repeat (12) send_tick(make_tick(5, 50, 0, 1, 0, 1, 3, 0, 0));
    send_tick(make_tick(90, 50, 0, 1, 0, 1, 0, 0, 0));
    send_tick(make_tick(90, 50, 0, 1, 1, 1, 0, 0, 0));
    send_tick(make_tick(90, 50, 0, 1, 0, 0, 0, 0, 0));
    send_tick(make_tick(90, 50, 0, 0, 0, 1, 0, 0, 0));
    send_tick(make_tick(-500, 50, 0, 1, 0, 1, 0, 1, 1));
    send_tick(make_tick(-500, 50, 0, 1, 0, 1, 0, 1, 0));

    apply_setting(2, 5, 1, 100, 200, 300);
    run_phase(300);
    apply_setting(0, 0, 0, -500, -500, -500);
    run_phase(125);
    apply_setting(65535, 65535, 65535, 1500, 1500, 1500);
    run_phase(125);
    a1 = int'($urandom_range(0, 800)) - 500;
    a2 = a1 + int'($urandom_range(0, 400));
    apply_setting($urandom_range(0, 4), $urandom_range(1, 30), $urandom_range(0, 1),
                  a1, a2, a2 + int'($urandom_range(0, 400)));
    run_phase(250);
    quiet = 1'b1;
    apply_setting(1, 20, 1, int'($urandom_range(0, 2000)) - 500,
                  int'($urandom_range(0, 2000)) - 500, int'($urandom_range(0, 2000)) - 500);
    run_phase(225);

    drain();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_status.size() == 0) begin
      $display("** compressor_thermostat_control_unit: PASSED **");
    end else begin
      $display("** compressor_thermostat_control_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("** compressor_thermostat_control_unit: FAILED **");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/ctc_pkg.sv
hw/rtl/ctc_air_step.sv
hw/rtl/ctc_core.sv
hw/rtl/compressor_thermostat_control_unit.sv
hw/rtl/ctc_checker.sv
dv/compressor_thermostat_control_unit_tb.sv
